/* src/soc_pkg.sv */
// soc_pkg: shared types, sizes and codes of the stable ordered collection
// no dependencies; imported by every module of the block
package soc_pkg;

    // sizes
    localparam int CAP_MAX  = 16;
    localparam int CNT_W    = $clog2(CAP_MAX + 1);
    localparam int KEY_W    = 32;
    localparam int HANDLE_W = 32;
    localparam int CFG_W    = 5;
    localparam int FILL_W   = 5;

    // operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_LIST = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_INVALID  = 2'd1;
    localparam logic [1:0] STAT_NO_SPACE = 2'd2;
    localparam logic [1:0] STAT_LISTED   = 2'd3;

    // cell commands
    localparam logic [1:0] CELL_HOLD  = 2'd0;
    localparam logic [1:0] CELL_NEW   = 2'd1;
    localparam logic [1:0] CELL_LEFT  = 2'd2;
    localparam logic [1:0] CELL_RIGHT = 2'd3;

    // one stored entry
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [HANDLE_W-1:0]     name;
        logic [HANDLE_W-1:0]     item;
    } t_entry;

    // control from the sequencer to one cell
    typedef struct packed {
        logic       valid;
        logic [1:0] cmd;
    } t_cell_ctrl;

    // input item
    typedef struct packed {
        logic                    operation;
        logic signed [KEY_W-1:0] sort_key;
        logic [HANDLE_W-1:0]     name_handle;
        logic [HANDLE_W-1:0]     item_handle;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [1:0]              status;
        logic signed [KEY_W-1:0] key_out;
        logic [HANDLE_W-1:0]     name_out;
        logic [HANDLE_W-1:0]     item_out;
        logic                    last;
        logic [FILL_W-1:0]       fill_count;
    } t_out_item;

endpackage

/* src/soc_cell.sv */
// soc_cell: one slot of the sorted chain, holds an entry and trades it with its neighbors
// depends on soc_pkg
module soc_cell import soc_pkg::*; (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_new,
    input  t_entry     i_left,
    input  t_entry     i_right,
    output t_entry     o_entry,
    output logic       o_past
);

    t_entry r_entry;

    // entry register, loaded from the new item or a neighbor
    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            CELL_NEW:   r_entry <= i_new;
            CELL_LEFT:  r_entry <= i_left;
            CELL_RIGHT: r_entry <= i_right;
            default:    r_entry <= r_entry;
        endcase
    end

    // slot lies at or past the insert point: empty, or key strictly above the new key
    assign o_past  = !i_ctrl.valid || ($signed(r_entry.key) > $signed(i_new.key));
    assign o_entry = r_entry;

endmodule

/* src/stable_ordered_collection_unit.sv */
// stable_ordered_collection_unit: top level, sequencer plus a sorted chain of soc_cell slots
// depends on soc_pkg and soc_cell
//
// Usage:
//   Input channel i_in_valid / o_in_ready carries t_in_item. An add item inserts its entry
//   into the chain, after every stored entry whose key is not greater, and gives
//   one result item (ok, invalid argument for a null name, or no space).
//   A list item streams the stored entries from the head cell, one per cycle while
//   the receiver takes them, in ascending key order with equal keys in arrival
//   order; the chain rotates by one slot for each item sent, so after n items it
//   is back in place. An empty list gives no result.
//   Output channel o_out_valid / i_out_ready carries t_out_item through one output
//   register. An add result shows in the cycle after acceptance; the first entry of
//   a list passes the state register and then the output register. A list holds the
//   input off while its entries stream, plus any stall.
//   A stalled receiver freezes the output register and the rotation; an add is
//   still taken while a result waits if the receiver takes it the same cycle.
//   Capacity is written through i_cfg_we / i_cfg_wdata; values above the chain
//   length act as the chain length.
//   Reset (synchronous, active low) empties the collection, drops any pending
//   result and sets the capacity to the chain length; the cells need no clearing.
module stable_ordered_collection_unit import soc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LIST = 1'b1;

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CFG_W-1:0] r_cap;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out_item, n_out_item;

    t_entry           w_new;
    t_entry           w_cell [CAP_MAX];
    t_cell_ctrl       w_ctrl [CAP_MAX];
    logic [CAP_MAX-1:0] w_past;

    logic             w_out_free;
    logic             w_accept;
    logic             w_full;
    logic             w_do_add;
    logic             w_emit;
    logic             w_last;

    // handshake
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    // add decision
    assign w_new.key  = i_in_item.sort_key;
    assign w_new.name = i_in_item.name_handle;
    assign w_new.item = i_in_item.item_handle;
    assign w_full     = (32'(r_count) >= 32'(r_cap)) || (32'(r_count) >= CAP_MAX);
    assign w_do_add   = w_accept && (i_in_item.operation == OP_ADD)
                        && (i_in_item.name_handle != '0) && !w_full;

    // list streaming
    assign w_emit = (r_state == ST_LIST) && w_out_free;
    assign w_last = (r_idx == r_count - CNT_W'(1));

    // chain of cells
    for (genvar g = 0; g < CAP_MAX; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        if (g == 0) begin : g_head
            assign w_left = w_new;
        end else begin : g_body
            assign w_left = w_cell[g-1];
        end
        if (g == CAP_MAX - 1) begin : g_tail
            assign w_right = w_cell[0];
        end else begin : g_inner
            assign w_right = (CNT_W'(g) == r_count - CNT_W'(1)) ? w_cell[0] : w_cell[g+1];
        end
        soc_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl[g]),
            .i_new   (w_new),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_cell[g]),
            .o_past  (w_past[g])
        );
    end

    // per-cell commands: shift right on insert, rotate left on list
    always_comb begin
        for (int i = 0; i < CAP_MAX; i++) begin
            w_ctrl[i].valid = (CNT_W'(i) < r_count);
            w_ctrl[i].cmd   = CELL_HOLD;
            if (w_do_add) begin
                if (w_past[i]) begin
                    if (i > 0 && w_past[(i > 0) ? i - 1 : 0]) begin
                        w_ctrl[i].cmd = CELL_LEFT;
                    end else begin
                        w_ctrl[i].cmd = CELL_NEW;
                    end
                end
            end else if (w_emit && w_ctrl[i].valid) begin
                w_ctrl[i].cmd = CELL_RIGHT;
            end
        end
    end

    // sequencer and output register next values
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_item.operation == OP_ADD) begin
                        n_out_valid           = 1'b1;
                        n_out_item.key_out    = '0;
                        n_out_item.name_out   = '0;
                        n_out_item.item_out   = '0;
                        n_out_item.last       = 1'b1;
                        n_out_item.fill_count = FILL_W'(r_count);
                        if (i_in_item.name_handle == '0) begin
                            n_out_item.status = STAT_INVALID;
                        end else if (w_full) begin
                            n_out_item.status = STAT_NO_SPACE;
                        end else begin
                            n_out_item.status     = STAT_OK;
                            n_count               = r_count + CNT_W'(1);
                            n_out_item.fill_count = FILL_W'(r_count + CNT_W'(1));
                        end
                    end else if (r_count != '0) begin
                        n_state = ST_LIST;
                        n_idx   = '0;
                    end
                end
            end
            ST_LIST: begin
                if (w_emit) begin
                    n_out_valid           = 1'b1;
                    n_out_item.status     = STAT_LISTED;
                    n_out_item.key_out    = w_cell[0].key;
                    n_out_item.name_out   = w_cell[0].name;
                    n_out_item.item_out   = w_cell[0].item;
                    n_out_item.last       = w_last;
                    n_out_item.fill_count = FILL_W'(r_count);
                    n_idx                 = r_idx + CNT_W'(1);
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_cap       <= CFG_W'(CAP_MAX);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* src/soc_checker.sv */
// soc_checker: port-level assertions for stable_ordered_collection_unit, bound to the top
// depends on soc_pkg
module soc_checker import soc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // reset leaves no pending result
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    // add answers are single results
    a_add_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status != STAT_LISTED) |-> o_out_item.last)
        else $error("add result without last flag");

    // input stays closed while a list is still streaming
    a_list_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.status == STAT_LISTED)
        && !o_out_item.last |-> !o_in_ready)
        else $error("input opened during a list");

endmodule

bind stable_ordered_collection_unit soc_checker u_soc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

/* bench/collection_checker.sv */
`timescale 1ns / 1ps
// collection_checker: follows the stable ordered collection from its channels, predicts
// every result item and compares each accepted result field by field; needs soc_pkg
module collection_checker import soc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  t_in_item         i_in_item,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  t_out_item        i_out_item,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output int               o_fail_count,
    output int               o_pending
);

    // shadow copy of the collection and of the capacity register
    t_entry           shadow_entries [CAP_MAX];
    int               shadow_count;
    logic [CFG_W-1:0] shadow_cap;
    // results owed by the block, oldest first
    t_out_item        owed_results [$];
    int               mismatch_total = 0;

    // report one differing field, returns 1 on a mismatch
    function automatic int field_diff(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", fname, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        t_out_item res;
        t_entry    order [CAP_MAX];
        t_entry    cur;
        int        cap_eff;
        int        n;
        int        i;
        int        j;
        if (!i_rst_n) begin
            shadow_count = 0;
            shadow_cap   = CFG_W'(CAP_MAX);
            owed_results.delete();
        end else begin
            // compare an accepted result with the oldest owed one
            if (i_out_valid && i_out_ready) begin
                got = i_out_item;
                if (owed_results.size() == 0) begin
                    $error("result item with nothing owed: status %0d key %0h",
                           got.status, got.key_out);
                    mismatch_total++;
                end else begin
                    want = owed_results.pop_front();
                    mismatch_total += field_diff("status", want.status, got.status);
                    mismatch_total += field_diff("key_out", want.key_out, got.key_out);
                    mismatch_total += field_diff("name_out", want.name_out, got.name_out);
                    mismatch_total += field_diff("item_out", want.item_out, got.item_out);
                    mismatch_total += field_diff("last", want.last, got.last);
                    mismatch_total += field_diff("fill_count", want.fill_count,
                                                 got.fill_count);
                end
            end

            // predict the results of an accepted input item
            if (i_in_valid && i_in_ready) begin
                res      = '0;
                res.last = 1'b1;
                cap_eff  = (shadow_cap > CAP_MAX) ? CAP_MAX : int'(shadow_cap);
                if (i_in_item.operation == OP_ADD) begin
                    // null name is tested before the capacity
                    if (i_in_item.name_handle == '0) begin
                        res.status = STAT_INVALID;
                    end else if (shadow_count >= cap_eff) begin
                        res.status = STAT_NO_SPACE;
                    end else begin
                        shadow_entries[shadow_count].key  = i_in_item.sort_key;
                        shadow_entries[shadow_count].name = i_in_item.name_handle;
                        shadow_entries[shadow_count].item = i_in_item.item_handle;
                        shadow_count++;
                        res.status = STAT_OK;
                    end
                    res.fill_count = FILL_W'(shadow_count);
                    owed_results.push_back(res);
                end else begin
                    // stable insertion sort: equal keys keep arrival order
                    n = shadow_count;
                    for (i = 0; i < n; i++) order[i] = shadow_entries[i];
                    for (i = 1; i < n; i++) begin
                        cur = order[i];
                        j   = i;
                        while (j > 0 && $signed(order[j-1].key) > $signed(cur.key)) begin
                            order[j] = order[j-1];
                            j--;
                        end
                        order[j] = cur;
                    end
                    for (i = 0; i < n; i++) begin
                        res.status     = STAT_LISTED;
                        res.key_out    = order[i].key;
                        res.name_out   = order[i].name;
                        res.item_out   = order[i].item;
                        res.last       = (i == n - 1);
                        res.fill_count = FILL_W'(shadow_count);
                        owed_results.push_back(res);
                    end
                end
            end

            // capacity writes are to happen only while the block is idle; the block does not enforce it
            if (i_cfg_we) begin
                shadow_cap = i_cfg_wdata;
            end
        end
        o_fail_count <= mismatch_total;
        o_pending    <= owed_results.size();
    end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// testbench: drives add and list items and capacity writes into the stable ordered
// collection with random idling; depends on soc_pkg, the block and collection_checker
module testbench;
    import soc_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 150;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    t_in_item         in_item;
    logic             out_valid;
    logic             out_ready;
    t_out_item        out_item;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               fail_count;
    int               pending;
    bit               tx_gaps;
    bit               rx_gaps;
    bit               hold_req;

    stable_ordered_collection_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    collection_checker u_collection_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // offer one item, with a random gap ahead of it, and wait for its acceptance
    task automatic send_item(input logic op, input logic [31:0] key,
                             input logic [31:0] name, input logic [31:0] item);
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid              <= 1'b1;
        in_item.operation     <= op;
        in_item.sort_key      <= key;
        in_item.name_handle   <= name;
        in_item.item_handle   <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    // keys lean toward extremes and a few small values so that ties are common
    function automatic logic [31:0] pick_key();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0000_0000;
            4, 5: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    // random add and list items, some adds with a null name
    task automatic send_random(input int count);
        logic        op;
        logic [31:0] name;
        repeat (count) begin
            op   = ($urandom_range(0, 3) == 0) ? OP_LIST : OP_ADD;
            name = ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom;
            send_item(op, pick_key(), name, $urandom);
        end
    endtask

    // stop offering, wait until every owed result has come, then let the clock run on
    // as well, since an empty list leaves nothing to wait for
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_capacity(input logic [CFG_W-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // receiver: random stall bursts, or one long hold-off on request
    initial begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // watchdog: too long without any item accepted on either side
    initial begin : watchdog
        int stalled;
        stalled = 0;
        while (stalled < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready)) stalled = 0;
            else stalled++;
        end
        $display("Mismatches found");
        $finish;
    end

    // stimulus and verdict
    initial begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        tx_gaps   = 1'b1;
        rx_gaps   = 1'b1;
        hold_req  = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, null name, extreme keys and ties at the reset capacity
        send_item(OP_LIST, 32'h0, 32'h0, 32'h0);
        send_item(OP_ADD, 32'd5, 32'h0, 32'hffff_ffff);
        send_item(OP_ADD, 32'h7fff_ffff, 32'hffff_ffff, 32'h0);
        send_item(OP_ADD, 32'h8000_0000, 32'h1, 32'hffff_ffff);
        send_item(OP_ADD, 32'h0, 32'h8000_0000, 32'h1);
        send_item(OP_ADD, 32'hffff_ffff, 32'h2, 32'h2);
        send_item(OP_ADD, 32'd5, 32'h3, 32'h3);
        send_item(OP_ADD, 32'd5, 32'h4, 32'h4);
        send_item(OP_ADD, 32'h8000_0000, 32'h5, 32'h5);
        send_item(OP_LIST, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

        // zero capacity: adds fail, null name still reported first
        set_capacity(5'd0);
        send_item(OP_ADD, 32'd9, 32'h6, 32'h6);
        send_item(OP_ADD, 32'd9, 32'h0, 32'h6);
        send_item(OP_LIST, 32'h0, 32'h0, 32'h0);

        // capacity reached exactly
        set_capacity(5'd8);
        send_item(OP_ADD, 32'd5, 32'h7, 32'h7);
        send_item(OP_ADD, 32'd1, 32'h8, 32'h8);
        send_item(OP_ADD, 32'd1, 32'h0, 32'h9);
        send_item(OP_LIST, 32'h0, 32'h0, 32'h0);

        // capacity above the chain length fills the collection
        set_capacity(5'd31);
        send_random(40);

        // long receiver hold-off while lists keep coming, then a pause
        hold_req = 1'b1;
        repeat (6) send_item(OP_LIST, $urandom, $urandom, $urandom);
        drain();
        send_random(40);

        // capacity lowered below the count
        set_capacity(5'd4);
        send_random(45);
        set_capacity(5'd16);
        send_random(45);
        set_capacity(5'($urandom_range(0, 31)));
        send_random(45);

        // last part without idling
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        drain();
        send_random(40);

        drain();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/soc_pkg.sv
src/soc_cell.sv
src/stable_ordered_collection_unit.sv
src/soc_checker.sv
bench/collection_checker.sv
bench/testbench.sv
